[rtl/etfi_pkg.sv]
// Package: shared types and constants of the escape-time fractal iterator.
`default_nettype none
package etfi_pkg;
    localparam int ModeW  = 3;
    localparam int IterW  = 12;
    localparam int ScaleW = 8;
    localparam int ValW   = 20;
    localparam int CfgW   = 32;
    localparam int IdxW   = 3;

    typedef enum logic [IdxW-1:0] {
        REG_MODE  = 3'd0,
        REG_MAXIT = 3'd1,
        REG_SCALE = 3'd2,
        REG_JRE   = 3'd3,
        REG_JIM   = 3'd4
    } t_reg_idx;

    typedef enum logic [ModeW-1:0] {
        MODE_MANDEL  = 3'd0,
        MODE_JULIA   = 3'd1,
        MODE_CUBIC   = 3'd2,
        MODE_SHIP    = 3'd3,
        MODE_PHOENIX = 3'd4
    } t_mode;

    typedef enum logic [4:0] {
        ST_IDLE, ST_INIT, ST_ABS, ST_SQ_RR, ST_SQ_II, ST_SQ_RI, ST_CUBE1, ST_CUBE2,
        ST_CUBE3, ST_CUBE4, ST_EPS_R, ST_EPS_I, ST_SUM, ST_MAG_R, ST_MAG_I, ST_TEST,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

[rtl/etfi_if.sv]
// Interface: valid/ready channel carrying a generic payload.
`default_nettype none
interface etfi_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/etfi_mul.sv]
// Shared signed multiplier with registered product.
`default_nettype none
module etfi_mul #(
    parameter int W = 32
) (
    input  wire logic                  i_clk,
    input  wire logic signed [W-1:0]   i_a,
    input  wire logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0]      o_p
);
    logic signed [2*W-1:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p;
endmodule
`default_nettype wire

[rtl/escape_time_fractal_iterator.sv]
// Top level: escape-time fractal iterator (five modes) with one shared multiplier.
`default_nettype none
// One point per item. A small sequencer drives a single registered multiplier,
// one product per cycle. An iteration issues 3 products for the square (+4 for the
// cubic step, +2 for Phoenix), then a state that adds the constant, then
// 2 products for the exact escape test and a state to compare; Burning Ship
// also spends a state on the abs step. The result becomes valid as the
// sequencer leaves its done state, and the next point can be accepted in the
// cycle in which the result becomes valid. The block is not ready while a point
// runs. The result sits in its own output register, so the next point may start
// while a result waits; a finished point holds until the output register is free.
// Fixed point is Q(COORD_WIDTH-FRAC_BITS).FRAC_BITS; products round toward minus
// infinity and every sum saturates.
module escape_time_fractal_iterator #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 24
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [etfi_pkg::IdxW-1:0]    i_cfg_idx,
    input  wire logic [etfi_pkg::CfgW-1:0]    i_cfg_data,
    etfi_if.sink                              in_ch,
    etfi_if.source                            out_ch
);
    localparam int W  = COORD_WIDTH;
    localparam int PW = 2*W;
    localparam int SW = W + 2;
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] EPS  = -(W'(1) <<< (FRAC_BITS-1));
    localparam longint PC_Q = (longint'(5667) * (longint'(1) <<< FRAC_BITS) + 5000) / 10000;
    localparam logic signed [W-1:0] PHX_C =
        (PC_Q > ((longint'(1) <<< (W-1)) - 1) && W < 64) ? MAXV : W'(PC_Q);
    localparam logic [PW+1:0] FOUR = (PW+2)'(1) << (2*FRAC_BITS + 2);

    // configuration
    logic [etfi_pkg::ModeW-1:0]  r_mode;
    logic [etfi_pkg::IterW-1:0]  r_maxit;
    logic [etfi_pkg::ScaleW-1:0] r_scale;
    logic signed [W-1:0]         r_jre, r_jim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0; r_maxit <= etfi_pkg::IterW'(100); r_scale <= 8'd1;
            r_jre <= '0; r_jim <= '0;
        end else if (i_cfg_we) begin
            unique case (etfi_pkg::t_reg_idx'(i_cfg_idx))
                etfi_pkg::REG_MODE:  r_mode  <= i_cfg_data[etfi_pkg::ModeW-1:0];
                etfi_pkg::REG_MAXIT: r_maxit <= i_cfg_data[etfi_pkg::IterW-1:0];
                etfi_pkg::REG_SCALE: r_scale <= i_cfg_data[etfi_pkg::ScaleW-1:0];
                etfi_pkg::REG_JRE:   r_jre   <= W'($signed(i_cfg_data));
                etfi_pkg::REG_JIM:   r_jim   <= W'($signed(i_cfg_data));
                default: ;
            endcase
        end
    end

    function automatic logic signed [W-1:0] f_sat(input logic signed [PW-FRAC_BITS+1:0] v);
        if (v > $signed({{(PW-FRAC_BITS-W+2){1'b0}}, MAXV})) return MAXV;
        if (v < $signed({{(PW-FRAC_BITS-W+2){1'b1}}, MINV})) return MINV;
        return W'(v);
    endfunction

    // shifted product, wide enough to add two of them without overflow
    localparam int TW = PW - FRAC_BITS + 2;

    etfi_pkg::t_state r_st, n_st;
    logic [etfi_pkg::ModeW-1:0] r_m;
    logic signed [W-1:0] r_zr, r_zi, r_cr, r_ci, r_qr, r_qi, r_sr, r_si;
    logic signed [TW-1:0] r_acc;
    logic [PW+1:0] r_mag;
    logic [etfi_pkg::IterW-1:0] r_k;
    logic [etfi_pkg::ValW-1:0] r_val, r_oval;
    logic r_esc, r_oesc, r_ovalid;
    logic signed [W-1:0] m_a, m_b;
    logic signed [PW-1:0] m_p;
    logic signed [TW-1:0] p_sh;
    logic [PW-1:0] p_abs;

    etfi_mul #(.W(W)) u_mul (.i_clk(i_clk), .i_a(m_a), .i_b(m_b), .o_p(m_p));
    assign p_sh  = TW'(m_p >>> FRAC_BITS);
    assign p_abs = PW'(m_p);

    function automatic logic signed [W-1:0] f_abs(input logic signed [W-1:0] v);
        if (v == MINV) return MAXV;
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [W-1:0] f_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        return f_sat(TW'(a) + TW'(b));
    endfunction

    logic is_cubic, is_phx, is_ship;
    assign is_cubic = r_m == etfi_pkg::MODE_CUBIC;
    assign is_phx   = r_m == etfi_pkg::MODE_PHOENIX;
    assign is_ship  = r_m == etfi_pkg::MODE_SHIP;

    // multiplier operands per state (product appears in the following state)
    always_comb begin
        m_a = r_zr; m_b = r_zr;
        unique case (r_st)
            etfi_pkg::ST_SQ_RR: begin m_a = r_zr; m_b = r_zr; end
            etfi_pkg::ST_SQ_II: begin m_a = r_zi; m_b = r_zi; end
            etfi_pkg::ST_SQ_RI: begin m_a = r_zr; m_b = r_zi; end
            etfi_pkg::ST_CUBE1: begin m_a = r_sr; m_b = r_zr; end
            etfi_pkg::ST_CUBE2: begin m_a = r_si; m_b = r_zi; end
            etfi_pkg::ST_CUBE3: begin m_a = r_sr; m_b = r_zi; end
            etfi_pkg::ST_CUBE4: begin m_a = r_si; m_b = r_zr; end
            etfi_pkg::ST_EPS_R: begin m_a = EPS;  m_b = r_qr; end
            etfi_pkg::ST_EPS_I: begin m_a = EPS;  m_b = r_qi; end
            etfi_pkg::ST_MAG_R: begin m_a = r_sr; m_b = r_sr; end
            etfi_pkg::ST_MAG_I: begin m_a = r_si; m_b = r_si; end
            default: ;
        endcase
    end

    // r_pst tells the sum stage which path produced the pending product
    logic signed [TW-1:0] r_p1;
    logic signed [W-1:0] r_nr;
    etfi_pkg::t_state r_pst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pst <= etfi_pkg::ST_IDLE;
        else          r_pst <= r_st;
    end

    logic test_esc, test_last, out_free;
    assign test_esc  = (r_mag + {2'b0, p_abs}) > FOUR;
    assign test_last = (r_k + 1'b1) == r_maxit;
    assign out_free  = !r_ovalid || out_ch.ready;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            etfi_pkg::ST_IDLE:  if (in_ch.valid) n_st = etfi_pkg::ST_INIT;
            etfi_pkg::ST_INIT:  n_st = (r_maxit == '0) ? etfi_pkg::ST_DONE :
                                       (is_ship ? etfi_pkg::ST_ABS : etfi_pkg::ST_SQ_RR);
            etfi_pkg::ST_ABS:   n_st = etfi_pkg::ST_SQ_RR;
            etfi_pkg::ST_SQ_RR: n_st = etfi_pkg::ST_SQ_II;
            etfi_pkg::ST_SQ_II: n_st = etfi_pkg::ST_SQ_RI;
            etfi_pkg::ST_SQ_RI: n_st = is_cubic ? etfi_pkg::ST_CUBE1 :
                                       is_phx ? etfi_pkg::ST_EPS_R : etfi_pkg::ST_SUM;
            etfi_pkg::ST_CUBE1: n_st = etfi_pkg::ST_CUBE2;
            etfi_pkg::ST_CUBE2: n_st = etfi_pkg::ST_CUBE3;
            etfi_pkg::ST_CUBE3: n_st = etfi_pkg::ST_CUBE4;
            etfi_pkg::ST_CUBE4: n_st = etfi_pkg::ST_SUM;
            etfi_pkg::ST_EPS_R: n_st = etfi_pkg::ST_EPS_I;
            etfi_pkg::ST_EPS_I: n_st = etfi_pkg::ST_SUM;
            etfi_pkg::ST_SUM:   n_st = etfi_pkg::ST_MAG_R;
            etfi_pkg::ST_MAG_R: n_st = etfi_pkg::ST_MAG_I;
            etfi_pkg::ST_MAG_I: n_st = etfi_pkg::ST_TEST;
            etfi_pkg::ST_TEST:  n_st = (test_esc || test_last) ? etfi_pkg::ST_DONE :
                                       (is_ship ? etfi_pkg::ST_ABS : etfi_pkg::ST_SQ_RR);
            etfi_pkg::ST_DONE:  n_st = out_free ? etfi_pkg::ST_IDLE : etfi_pkg::ST_DONE;
            default:            n_st = etfi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= etfi_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            if (r_st == etfi_pkg::ST_DONE && out_free) r_ovalid <= 1'b1;
        end
    end

    // datapath; products of state S are consumed in the following state
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            etfi_pkg::ST_IDLE: if (in_ch.valid) begin
                r_m <= r_mode;
                r_zr <= '0; r_zi <= '0; r_qr <= '0; r_qi <= '0;
                r_cr <= in_ch.data[W-1:0]; r_ci <= in_ch.data[2*W-1:W];
                if (r_mode == etfi_pkg::MODE_JULIA) begin
                    r_zr <= in_ch.data[W-1:0]; r_zi <= in_ch.data[2*W-1:W];
                    r_cr <= r_jre; r_ci <= r_jim;
                end else if (r_mode == etfi_pkg::MODE_PHOENIX) begin
                    r_zr <= in_ch.data[2*W-1:W]; r_zi <= in_ch.data[W-1:0];
                    r_cr <= PHX_C; r_ci <= '0;
                end
            end
            etfi_pkg::ST_INIT: begin
                r_k <= '0; r_esc <= 1'b0; r_val <= etfi_pkg::ValW'(r_maxit);
            end
            etfi_pkg::ST_ABS: begin r_zr <= f_abs(r_zr); r_zi <= f_abs(r_zi); end
            etfi_pkg::ST_SQ_II: r_p1 <= p_sh;                       // rr
            etfi_pkg::ST_SQ_RI: r_sr <= f_sat(r_p1 - p_sh);         // rr - ii
            etfi_pkg::ST_CUBE1: r_si <= f_sat(p_sh + p_sh);         // 2ri
            etfi_pkg::ST_EPS_R: r_si <= f_sat(p_sh + p_sh);
            etfi_pkg::ST_SUM: begin
                if (r_pst == etfi_pkg::ST_SQ_RI) begin
                    r_si <= f_add(f_sat(p_sh + p_sh), r_ci);
                    r_sr <= f_add(r_sr, r_cr);
                end else if (r_pst == etfi_pkg::ST_CUBE4) begin
                    r_si <= f_add(f_sat(r_acc + p_sh), r_ci);
                    r_sr <= f_add(r_nr, r_cr);
                end else begin
                    r_si <= f_add(f_add(r_si, r_ci), f_sat(p_sh));
                    r_sr <= r_nr;
                end
                // new z is complete here; the magnitude products follow
            end
            etfi_pkg::ST_CUBE2: r_p1 <= p_sh;                       // sr*zr
            etfi_pkg::ST_CUBE3: r_nr <= f_sat(r_p1 - p_sh);
            etfi_pkg::ST_CUBE4: r_acc <= p_sh;                      // sr*zi
            etfi_pkg::ST_EPS_I: r_nr <= f_add(f_add(r_sr, r_cr), f_sat(p_sh));
            etfi_pkg::ST_MAG_I: ;
            etfi_pkg::ST_TEST: begin
                r_qr <= r_zr; r_qi <= r_zi;
                r_zr <= r_sr; r_zi <= r_si;
                r_k <= r_k + 1'b1;
                if (test_esc) begin
                    r_esc <= 1'b1;
                    r_val <= etfi_pkg::ValW'(r_k) * etfi_pkg::ValW'(r_scale);
                end
            end
            etfi_pkg::ST_DONE: if (out_free) begin
                r_oval <= r_val;
                r_oesc <= r_esc;
            end
            default: ;
        endcase
        if (r_st == etfi_pkg::ST_MAG_I) r_mag <= {2'b0, p_abs};
    end

    assign in_ch.ready  = (r_st == etfi_pkg::ST_IDLE);
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = {r_oesc, r_oval};

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != etfi_pkg::ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
    a_done_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == etfi_pkg::ST_DONE) |=> out_ch.valid) else $error("result lost");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == etfi_pkg::ST_TEST) |-> (r_k < r_maxit)) else $error("iteration overrun");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
        else $error("result changed while waiting");
`endif
endmodule
`default_nettype wire
